FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define DCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("dcc assertion failed");

// checked on every rising edge, reset included
`define DCC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("dcc assertion failed during reset");

`endif

FILE: rtl/dcc_pkg.sv
// types and constants shared by the depthwise causal conv1d unit
`timescale 1ns / 1ps
`default_nettype none

package dcc_pkg;

	localparam int VALUE_W      = 16;
	localparam int CHAN_W       = 6;
	localparam int TAP_IN_W     = 2;
	localparam int TAPS_W       = 3;
	localparam int SHIFT_W      = 4;
	localparam int DEF_CHANNELS = 64;
	localparam int DEF_MAX_TAPS = 4;
	localparam int MID_DEPTH    = 4;
	localparam int OUT_DEPTH    = 8;
	localparam int FRAC_SHIFT   = 14;
	localparam int ROUND_HALF   = 8192;
	localparam int OUT_MAX      = 32767;
	localparam int OUT_MIN      = -32768;

	localparam logic [TAPS_W-1:0] TAPS_RESET = 3'd4;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_WEIGHT = 2'd1,
		CMD_BIAS   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_WEIGHT,
		KIND_BIAS
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [CHAN_W-1:0]          channel;
		logic [TAP_IN_W-1:0]        tap;
		logic signed [VALUE_W-1:0]  value;
		logic                       sos;
		logic [SHIFT_W-1:0]         shift;
	} mid_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value;
		logic [CHAN_W-1:0]          channel;
		logic                       sat;
	} out_item_t;

endpackage

`default_nettype wire

FILE: rtl/depthwise_causal_conv1d_unit.sv
// a sample word passes the front queue, the multiply-accumulate pipeline and the result
// queue; throughput: one word per cycle while full is low; up to twelve accepted samples
// may wait to be popped, four in the front queue and eight issued to the pipeline or the
// result queue; coefficient and bias loads take one queue slot and give no result
// reset: clears the tap count to four and starts a sweep of all CHANNELS (64 by default)
// that zeroes weights, biases and history; full stays high until it is done
`timescale 1ns / 1ps
`default_nettype none

module depthwise_causal_conv1d_unit import dcc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [1:0]                command,
	input  wire logic [CHAN_W-1:0]         channel,
	input  wire logic [TAP_IN_W-1:0]       tap,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic                      start_of_sequence,
	input  wire logic                      pop,
	output logic                           empty,
	output logic signed [VALUE_W-1:0]      out_value,
	output logic [CHAN_W-1:0]              out_channel,
	output logic                           saturated,
	input  wire logic                      cfg_write,
	input  wire logic [TAPS_W-1:0]         cfg_data
);

	logic      mid_full;
	logic      mid_empty;
	logic      mid_push;
	logic      mid_pop;
	mid_item_t mid_in;
	mid_item_t mid_head;
	logic      clearing;
	logic      res_push;
	out_item_t res_item;
	out_item_t out_head;
	logic      res_taken;

	dcc_front #(
		.CHANNELS(CHANNELS),
		.MAX_TAPS(MAX_TAPS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.command          (command),
		.channel          (channel),
		.tap              (tap),
		.value            (value),
		.start_of_sequence(start_of_sequence),
		.cfg_write        (cfg_write),
		.cfg_data         (cfg_data),
		.mid_full         (mid_full),
		.clearing         (clearing),
		.full             (full),
		.mid_push         (mid_push),
		.mid_item         (mid_in)
	);

	dcc_queue #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_in),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_head),
		.empty (mid_empty)
	);

	dcc_back #(
		.CHANNELS(CHANNELS),
		.MAX_TAPS(MAX_TAPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!mid_empty),
		.head      (mid_head),
		.head_pop  (mid_pop),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_taken (res_taken),
		.clearing  (clearing)
	);

	assign res_taken = pop && !empty;

	dcc_queue #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_item),
		.full  (),
		.pop   (pop),
		.rdata (out_head),
		.empty (empty)
	);

	assign out_value   = out_head.value;
	assign out_channel = out_head.channel;
	assign saturated   = out_head.sat;

endmodule

`default_nettype wire

FILE: rtl/dcc_queue.sv
// small first-in first-out queue of registers
`timescale 1ns / 1ps
`default_nettype none

module dcc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dcc_front.sv
// front end: tap count register, input handshake and command decode
`timescale 1ns / 1ps
`default_nettype none

module dcc_front import dcc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [1:0]                command,
	input  wire logic [CHAN_W-1:0]         channel,
	input  wire logic [TAP_IN_W-1:0]       tap,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic                      start_of_sequence,
	input  wire logic                      cfg_write,
	input  wire logic [TAPS_W-1:0]         cfg_data,
	input  wire logic                      mid_full,
	input  wire logic                      clearing,
	output logic                           full,
	output logic                           mid_push,
	output mid_item_t                      mid_item
);

	logic [TAPS_W-1:0]  taps_q;
	logic [SHIFT_W:0]   k_eff;
	logic               keep;
	kind_t              kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_RESET;
		end else if (cfg_write) begin
			taps_q <= cfg_data;
		end
	end

	// zero taps acts as one, anything past the table as the table size
	always_comb begin
		priority if (taps_q == '0) begin
			k_eff = (SHIFT_W+1)'(1);
		end else if (32'(taps_q) > MAX_TAPS) begin
			k_eff = (SHIFT_W+1)'(MAX_TAPS);
		end else begin
			k_eff = (SHIFT_W+1)'(taps_q);
		end
	end

	always_comb begin
		keep = 1'b0;
		kind = KIND_SAMPLE;
		unique case (cmd_t'(command))
			CMD_SAMPLE: begin
				kind = KIND_SAMPLE;
				keep = 1'b1;
			end
			CMD_WEIGHT: begin
				kind = KIND_WEIGHT;
				keep = (32'(tap) < MAX_TAPS);
			end
			CMD_BIAS: begin
				kind = KIND_BIAS;
				keep = 1'b1;
			end
			default: begin
				kind = KIND_SAMPLE;
				keep = 1'b0;
			end
		endcase
		if (32'(channel) >= CHANNELS) begin
			keep = 1'b0;
		end
	end

	assign full     = mid_full || clearing;
	assign mid_push = push && !full && keep;

	always_comb begin
		mid_item.kind    = kind;
		mid_item.channel = channel;
		mid_item.tap     = tap;
		mid_item.value   = value;
		mid_item.sos     = start_of_sequence;
		mid_item.shift   = SHIFT_W'((SHIFT_W+1)'(MAX_TAPS) - k_eff);
	end

endmodule

`default_nettype wire

FILE: rtl/dcc_back.sv
// back end: coefficient and history memories, multiply-accumulate pipeline
`timescale 1ns / 1ps
`default_nettype none

module dcc_back import dcc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire mid_item_t head,
	output logic           head_pop,
	output logic           res_push,
	output out_item_t      res_item,
	input  wire logic      res_taken,
	output logic           clearing
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HIST_N = MAX_TAPS - 1;
	localparam int IDX_W  = $clog2(MAX_TAPS);
	localparam int PROD_W = 2 * VALUE_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1) + 1;
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	typedef logic signed [VALUE_W-1:0] word_t;
	typedef logic [HIST_N-1:0][VALUE_W-1:0] hist_row_t;

	// clearing sweep after reset
	logic              clr_busy_q;
	logic [CH_W-1:0]   clr_idx_q;
	logic [CRED_W-1:0] cred_q;

	logic              issue;
	logic              issue_sample;
	logic [CH_W-1:0]   rd_addr;
	logic [CH_W-1:0]   coef_waddr;
	word_t             coef_wdata;

	logic [MAX_TAPS-1:0][VALUE_W-1:0] w_rd;
	logic [VALUE_W-1:0]               bias_mem_q [CHANNELS];
	logic [VALUE_W-1:0]               bias_rd_q;
	logic                             bias_we;
	hist_row_t                        hist_mem_q [CHANNELS];
	hist_row_t                        hist_rd_q;
	logic                             hist_we;
	logic [CH_W-1:0]                  hist_waddr;
	hist_row_t                        hist_wdata;

	logic              v_s1;
	logic [CH_W-1:0]   ch_s1;
	word_t             value_s1;
	logic              sos_s1;
	logic [SHIFT_W-1:0] shift_s1;
	logic              byp_s1;
	hist_row_t         byp_row_s1;

	word_t             hist_eff [HIST_N];
	hist_row_t         new_row;
	word_t             win [MAX_TAPS];
	word_t             sel [MAX_TAPS];
	logic signed [PROD_W-1:0] mul [MAX_TAPS];

	logic              v_s2;
	logic [CH_W-1:0]   ch_s2;
	word_t             bias_s2;
	logic signed [PROD_W-1:0] prod_s2 [MAX_TAPS];

	logic signed [ACC_W-1:0] sum;
	logic              v_s3;
	logic [CH_W-1:0]   ch_s3;
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shr;

	assign clearing = clr_busy_q;

	// a sample needs a free slot in the result queue before it enters
	assign issue = head_valid && !clr_busy_q
		&& (head.kind != KIND_SAMPLE || cred_q < CRED_W'(OUT_DEPTH));
	assign issue_sample = issue && (head.kind == KIND_SAMPLE);
	assign head_pop     = issue;

	assign rd_addr    = CH_W'(head.channel);
	assign coef_waddr = clr_busy_q ? clr_idx_q : rd_addr;
	assign coef_wdata = clr_busy_q ? '0 : head.value;
	assign bias_we    = clr_busy_q || (issue && head.kind == KIND_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			cred_q     <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CH_W'(CHANNELS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			cred_q <= cred_q + CRED_W'(issue_sample) - CRED_W'(res_taken);
		end
	end

	// one weight memory per tap lane
	for (genvar j = 0; j < MAX_TAPS; j++) begin : gen_lane
		logic [VALUE_W-1:0] lane_mem_q [CHANNELS];
		logic [VALUE_W-1:0] lane_rd_q;
		logic               lane_we;

		assign lane_we = clr_busy_q
			|| (issue && head.kind == KIND_WEIGHT && 32'(head.tap) == j);

		always_ff @(posedge clk) begin
			if (lane_we) begin
				lane_mem_q[coef_waddr] <= coef_wdata;
			end
			lane_rd_q <= lane_mem_q[rd_addr];
		end

		assign w_rd[j] = lane_rd_q;
	end

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_mem_q[coef_waddr] <= coef_wdata;
		end
		bias_rd_q <= bias_mem_q[rd_addr];
	end

	assign hist_we    = clr_busy_q || v_s1;
	assign hist_waddr = clr_busy_q ? clr_idx_q : ch_s1;
	assign hist_wdata = clr_busy_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem_q[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem_q[rd_addr];
	end

	// stage 1: history and coefficients come back from the memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_sample;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_sample) begin
			ch_s1      <= rd_addr;
			value_s1   <= head.value;
			sos_s1     <= head.sos;
			shift_s1   <= head.shift;
			// same channel written back on this edge: the memory read is stale
			byp_s1     <= v_s1 && (ch_s1 == rd_addr);
			byp_row_s1 <= new_row;
		end
	end

	always_comb begin
		for (int i = 0; i < HIST_N; i++) begin
			if (sos_s1) begin
				hist_eff[i] = '0;
			end else if (byp_s1) begin
				hist_eff[i] = word_t'(byp_row_s1[i]);
			end else begin
				hist_eff[i] = word_t'(hist_rd_q[i]);
			end
		end
		for (int i = 0; i < HIST_N; i++) begin
			if (i < HIST_N - 1) begin
				new_row[i] = hist_eff[i + 1];
			end else begin
				new_row[i] = value_s1;
			end
		end
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (i < HIST_N) begin
				win[i] = hist_eff[i];
			end else begin
				win[i] = value_s1;
			end
		end
	end

	// tap j lines up with window slot shift + j; slots past the end are unused taps
	always_comb begin
		logic [SHIFT_W:0] idx;
		idx = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			idx = (SHIFT_W+1)'(shift_s1) + (SHIFT_W+1)'(j);
			if (idx < (SHIFT_W+1)'(MAX_TAPS)) begin
				sel[j] = win[idx[IDX_W-1:0]];
			end else begin
				sel[j] = '0;
			end
			mul[j] = PROD_W'(sel[j]) * PROD_W'(word_t'(w_rd[j]));
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		ch_s2   <= ch_s1;
		bias_s2 <= word_t'(bias_rd_q);
		for (int j = 0; j < MAX_TAPS; j++) begin
			prod_s2[j] <= mul[j];
		end
	end

	always_comb begin
		sum = ACC_W'(bias_s2) <<< FRAC_SHIFT;
		for (int j = 0; j < MAX_TAPS; j++) begin
			sum = sum + ACC_W'(prod_s2[j]);
		end
	end

	// stage 3: accumulated sum
	always_ff @(posedge clk) begin
		ch_s3  <= ch_s2;
		acc_s3 <= sum;
	end

	// round half up, then clamp
	assign rnd = acc_s3 + ACC_W'(ROUND_HALF);
	assign shr = rnd >>> FRAC_SHIFT;

	always_comb begin
		res_item.channel = CHAN_W'(ch_s3);
		priority if (shr > ACC_W'(OUT_MAX)) begin
			res_item.value = VALUE_W'(OUT_MAX);
			res_item.sat   = 1'b1;
		end else if (shr < ACC_W'(OUT_MIN)) begin
			res_item.value = VALUE_W'(OUT_MIN);
			res_item.sat   = 1'b1;
		end else begin
			res_item.value = shr[VALUE_W-1:0];
			res_item.sat   = 1'b0;
		end
	end

	assign res_push = v_s3;

endmodule

`default_nettype wire

FILE: rtl/dcc_checker.sv
// port-level checks for the depthwise causal conv1d unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcc_checker import dcc_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      push,
	input wire logic                      full,
	input wire logic [1:0]                command,
	input wire logic [CHAN_W-1:0]         channel,
	input wire logic                      pop,
	input wire logic                      empty,
	input wire logic signed [VALUE_W-1:0] out_value,
	input wire logic [CHAN_W-1:0]         out_channel,
	input wire logic                      saturated
);

	localparam int PEND_W = $clog2(MID_DEPTH + OUT_DEPTH + 1);

	logic              sample_in;
	logic              word_out;
	logic [PEND_W-1:0] pend_q;

	assign sample_in = push && !full && (cmd_t'(command) == CMD_SAMPLE)
		&& (32'(channel) < CHANNELS);
	assign word_out  = pop && !empty;

	// samples taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PEND_W'(sample_in) - PEND_W'(word_out);
		end
	end

	`DCC_ASSERT_ALWAYS(a_reset_closed, clk, !arst_n |-> full && empty)
	`DCC_ASSERT(a_no_extra_word, clk, arst_n, word_out |-> pend_q != '0)
	`DCC_ASSERT(a_hold_word, clk, arst_n, !empty && !pop |=> !empty && $stable(out_value) && $stable(out_channel) && $stable(saturated))
	`DCC_ASSERT(a_sat_clipped, clk, arst_n, !empty && saturated |-> out_value == 16'sh7fff || out_value == 16'sh8000)

endmodule

bind depthwise_causal_conv1d_unit dcc_checker #(
	.CHANNELS(CHANNELS)
) u_dcc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.push             (push),
	.full             (full),
	.command          (command),
	.channel          (channel),
	.pop              (pop),
	.empty            (empty),
	.out_value        (out_value),
	.out_channel      (out_channel),
	.saturated        (saturated)
);

`default_nettype wire
